### src/dq_pkg.sv
// Shared types and constants for the double-ended queue core.
`default_nettype none
package dq_pkg;

  // Default number of storage entries
  localparam int unsigned DEPTH_DEF = 64;

  // Fixed widths of the result fields
  localparam int unsigned OCC_W = 7;
  localparam int unsigned VAL_W = 32;

  // Request codes
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT  = 3'd0,
    REQ_PUSH_BACK   = 3'd1,
    REQ_REMOVE_FRNT = 3'd2,
    REQ_REMOVE_BACK = 3'd3,
    REQ_DUMP        = 3'd4
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Decoded action for one request word
  typedef struct packed {
    logic    wr_en;       // write in_value into the store
    logic    upd_head;    // take the new head index
    logic    upd_cnt;     // take the new element count
    logic    dump;        // start a walk over stored entries
    logic    dump_empty;  // dump of an empty queue
    status_t status;
  } op_t;

endpackage : dq_pkg
`default_nettype wire

### src/dq_decode.sv
// Request decoder: status, pointer update and store write address.
`default_nettype none
module dq_decode #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic [2:0]                     req,
  input  wire logic [$clog2(DEPTH)-1:0]       head,
  input  wire logic [$clog2(DEPTH+1)-1:0]     cnt,
  output dq_pkg::op_t                         op,
  output logic [$clog2(DEPTH)-1:0]            head_nxt,
  output logic [$clog2(DEPTH+1)-1:0]          cnt_nxt,
  output logic [$clog2(DEPTH)-1:0]            wr_addr
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_pos;

  // Wrap the circular positions
  always_comb begin
    full     = (cnt == CW'(DEPTH));
    empty    = (cnt == '0);
    head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
    head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
    // cnt is below DEPTH whenever the tail is used, so its low bits suffice
    tail_sum = {1'b0, head} + {1'b0, cnt[AW-1:0]};
    tail_pos = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                            : tail_sum[AW-1:0];
  end

  // Decide the action for this request
  always_comb begin
    op       = '0;
    op.status = dq_pkg::STAT_OK;
    head_nxt = head;
    cnt_nxt  = cnt;
    wr_addr  = tail_pos;
    case (req)
      dq_pkg::REQ_PUSH_FRONT: begin
        wr_addr = head_dec;
        if (full) begin
          op.status = dq_pkg::STAT_FULL;
        end else begin
          op.wr_en    = 1'b1;
          op.upd_head = 1'b1;
          op.upd_cnt  = 1'b1;
          head_nxt    = head_dec;
          cnt_nxt     = cnt + CW'(1);
        end
      end
      dq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          op.status = dq_pkg::STAT_FULL;
        end else begin
          op.wr_en   = 1'b1;
          op.upd_cnt = 1'b1;
          cnt_nxt    = cnt + CW'(1);
        end
      end
      dq_pkg::REQ_REMOVE_FRNT: begin
        if (empty) begin
          op.status = dq_pkg::STAT_EMPTY;
        end else begin
          op.upd_head = 1'b1;
          op.upd_cnt  = 1'b1;
          head_nxt    = head_inc;
          cnt_nxt     = cnt - CW'(1);
        end
      end
      dq_pkg::REQ_REMOVE_BACK: begin
        if (empty) begin
          op.status = dq_pkg::STAT_EMPTY;
        end else begin
          op.upd_cnt = 1'b1;
          cnt_nxt    = cnt - CW'(1);
        end
      end
      dq_pkg::REQ_DUMP: begin
        op.dump       = ~empty;
        op.dump_empty = empty;
      end
      default: begin
        op = '0;
        op.status = dq_pkg::STAT_OK;
      end
    endcase
  end

endmodule : dq_decode
`default_nettype wire

### src/double_ended_queue_core.sv
// Top level of the double-ended queue: circular store, dump walker, result registers.
// Push, remove and unused codes: one result in the cycle after accept; a new word every cycle while not busy.
// Dump of N stored words: busy while one entry a cycle is read from the store port into rd_q;
// each result is registered together with its read, the last one marked.
// Dump of an empty queue behaves like a push: one result in the cycle after accept.
// Reset clears head, count, walker and result strobe; store contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module double_ended_queue_core #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               in_req_type,
  input  wire logic signed [31:0]       in_value,
  output logic                          out_valid,
  output logic signed [31:0]            out_elem_value,
  output logic                          out_has_value,
  output logic                          out_is_last,
  output logic [6:0]                    out_occupancy,
  output logic [1:0]                    out_status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FS_IDLE = 2'b01,
    FS_DUMP = 2'b10
  } fsm_t;

  fsm_t                     state_r, state_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     valid_r, valid_nxt;
  logic                     has_r, has_nxt;
  logic                     last_r, last_nxt;
  logic [dq_pkg::OCC_W-1:0] occ_r, occ_nxt;
  dq_pkg::status_t          stat_r, stat_nxt;

  logic [dq_pkg::VAL_W-1:0] mem [DEPTH];
  logic [dq_pkg::VAL_W-1:0] rd_q;

  dq_pkg::op_t              op;
  logic [AW-1:0]            dec_head;
  logic [CW-1:0]            dec_cnt;
  logic [AW-1:0]            wr_addr;
  logic                     accept;
  logic                     walking;
  logic                     walk_end;

  dq_decode #(
    .DEPTH (DEPTH)
  ) u_decode (
    .req      (in_req_type),
    .head     (head_r),
    .cnt      (cnt_r),
    .op       (op),
    .head_nxt (dec_head),
    .cnt_nxt  (dec_cnt),
    .wr_addr  (wr_addr)
  );

  assign busy     = (state_r == FS_DUMP);
  assign accept   = start & ~busy;
  assign walking  = (state_r == FS_DUMP);
  assign walk_end = ((idx_r + CW'(1)) == cnt_r);

  // Store: write on an accepted push, read one entry per walk cycle.
  // Writes only happen in idle and reads only while walking, so the
  // two ports never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (accept && op.wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (walking) begin
      rd_q <= mem[ptr_r];
    end
  end

  // Next state of pointers, walker and result registers
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    valid_nxt = 1'b0;
    has_nxt   = 1'b0;
    last_nxt  = 1'b1;
    occ_nxt   = occ_r;
    stat_nxt  = stat_r;
    case (state_r)
      FS_IDLE: begin
        if (accept) begin
          if (op.upd_head) head_nxt = dec_head;
          if (op.upd_cnt)  cnt_nxt  = dec_cnt;
          if (op.dump) begin
            // start the walk at the front element
            state_nxt = FS_DUMP;
            ptr_nxt   = head_r;
            idx_nxt   = '0;
          end else begin
            valid_nxt = 1'b1;
            occ_nxt   = dq_pkg::OCC_W'(dec_cnt);
            stat_nxt  = op.status;
          end
        end
      end
      FS_DUMP: begin
        // emit one stored word, advance the walker
        valid_nxt = 1'b1;
        has_nxt   = 1'b1;
        last_nxt  = walk_end;
        occ_nxt   = dq_pkg::OCC_W'(cnt_r);
        stat_nxt  = dq_pkg::STAT_OK;
        ptr_nxt   = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + AW'(1);
        idx_nxt   = idx_r + CW'(1);
        if (walk_end) state_nxt = FS_IDLE;
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      ptr_r   <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
      has_r   <= 1'b0;
      last_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
      has_r   <= has_nxt;
      last_r  <= last_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    occ_r  <= occ_nxt;
    stat_r <= stat_nxt;
  end

  // Drive the result ports; the element is shown only for dump words
  assign out_valid      = valid_r;
  assign out_has_value  = has_r;
  assign out_is_last    = last_r;
  assign out_occupancy  = occ_r;
  assign out_status     = stat_r;
  assign out_elem_value = has_r ? $signed(rd_q) : '0;

  // Count never exceeds the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  // Every walk cycle produces a stored word on the next cycle
  a_walk_emits: assert property (@(posedge clk) disable iff (!rst_n)
    walking |=> (out_valid && out_has_value))
    else $error("walk cycle without a dump word");

  // The final walk cycle returns to idle and marks the last word
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (walking && walk_end) |=> (state_r == FS_IDLE && out_is_last))
    else $error("dump did not end with a marked word");

  // The store count is frozen during a walk
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    walking |=> $stable(cnt_r) && $stable(head_r))
    else $error("queue pointers moved during a dump");

  // A word without an element always closes its request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_value) |-> out_is_last)
    else $error("single result not marked last");

endmodule : double_ended_queue_core
`default_nettype wire
